>>> hdl/tad_pkg.sv
package tad_pkg;

   localparam logic [7:0] BYTE_BS    = 8'h08;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_CTRC  = 8'h03;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_TILDE = 8'h7E;
   localparam logic [7:0] BYTE_LBRK  = 8'h5B;  // '['
   localparam logic [7:0] BYTE_UCO   = 8'h4F;  // 'O'
   localparam logic [7:0] BYTE_UCA   = 8'h41;  // 'A'
   localparam logic [7:0] BYTE_UCB   = 8'h42;
   localparam logic [7:0] BYTE_UCC   = 8'h43;
   localparam logic [7:0] BYTE_UCD   = 8'h44;

   localparam logic [7:0] OPT_ECHO = 8'd1;
   localparam logic [7:0] OPT_SGA  = 8'd3;

   localparam logic [7:0] TN_BRK  = 8'd243;
   localparam logic [7:0] TN_IP   = 8'd244;
   localparam logic [7:0] TN_EC   = 8'd247;
   localparam logic [7:0] TN_EL   = 8'd248;
   localparam logic [7:0] TN_WILL = 8'd251;
   localparam logic [7:0] TN_WONT = 8'd252;
   localparam logic [7:0] TN_DO   = 8'd253;
   localparam logic [7:0] TN_DONT = 8'd254;
   localparam logic [7:0] TN_IAC  = 8'd255;

   // register word index on the configuration port
   localparam logic REG_TELNET_MODE = 1'b0;

   typedef enum logic [3:0] {
      EV_NONE       = 4'd0,
      EV_INSERT     = 4'd1,
      EV_DELETE     = 4'd2,
      EV_CTRL_C     = 4'd3,
      EV_TN_BREAK   = 4'd4,
      EV_ERASE_CHAR = 4'd5,
      EV_ERASE_LINE = 4'd6,
      EV_UP         = 4'd7,
      EV_DOWN       = 4'd8,
      EV_RIGHT      = 4'd9,
      EV_LEFT       = 4'd10,
      EV_REPLY      = 4'd11
   } event_type;

   typedef struct packed {
      event_type  event_res;
      logic [7:0] pass_byte;
      logic [7:0] reply_verb;
      logic [7:0] reply_option;
   } result_type;

endpackage

>>> hdl/telnet_ansi_key_decoder.sv
// Console key decoder: takes one received byte per transaction and returns exactly one
// edit event per byte, in the cycle after it is accepted. A new byte is accepted every
// cycle; the only limit on rate is the single result register, which holds a result until
// rsp_ready takes it and accepts the next byte in the same cycle it drains. ESC always opens
// a sequence, and IAC (255) does so when telnet_mode is set; telnet WILL/DO/WONT/DONT
// requests get a reply verb accepting ECHO and SUPPRESS-GO-AHEAD on WILL/DO, refusing the
// rest. Bytes 0x80 and above outside a sequence pass through with no event. telnet_mode
// is register 0 at byte address 0 and should only be written while the decoder is idle.
module telnet_ansi_key_decoder (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_event_res,
   output logic [7:0] rsp_pass_byte,
   output logic [7:0] rsp_reply_verb,
   output logic [7:0] rsp_reply_option,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                telnet_mode_ff;
   logic [1:0]          seq_count_ff, seq_count_in;
   logic                seq_is_telnet_ff, seq_is_telnet_in;
   logic [7:0]          seq_second_ff, seq_second_in;
   logic                rsp_valid_ff;
   tad_pkg::result_type rsp_ff, rsp_in;
   logic                accept;
   logic                csr_write;
   logic                lead;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == tad_pkg::REG_TELNET_MODE) ?
                       {31'd0, telnet_mode_ff} : 32'd0;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign lead = (req_rx_byte == tad_pkg::BYTE_ESC) ||
                 (telnet_mode_ff && (req_rx_byte == tad_pkg::TN_IAC));

   always_comb begin
      logic [7:0] b;
      logic       ok;
      b                = req_rx_byte;
      ok               = (b == tad_pkg::OPT_ECHO) || (b == tad_pkg::OPT_SGA);
      seq_count_in     = seq_count_ff;
      seq_is_telnet_in = seq_is_telnet_ff;
      seq_second_in    = seq_second_ff;
      rsp_in.event_res    = tad_pkg::EV_NONE;
      rsp_in.pass_byte    = 8'd0;
      rsp_in.reply_verb   = 8'd0;
      rsp_in.reply_option = 8'd0;

      if (lead) begin
         seq_is_telnet_in = (b == tad_pkg::TN_IAC);
         seq_count_in     = 2'd1;
      end else if (seq_count_ff != 2'd0 && seq_is_telnet_ff) begin
         if (seq_count_ff == 2'd1) begin
            seq_second_in = b;
            if (b inside {tad_pkg::TN_WILL, tad_pkg::TN_WONT,
                          tad_pkg::TN_DO, tad_pkg::TN_DONT}) begin
               seq_count_in = 2'd2;
            end else begin
               seq_count_in = 2'd0;
               if (b inside {tad_pkg::TN_BRK, tad_pkg::TN_IP})
                  rsp_in.event_res = tad_pkg::EV_TN_BREAK;
               else if (b == tad_pkg::TN_EC)
                  rsp_in.event_res = tad_pkg::EV_ERASE_CHAR;
               else if (b == tad_pkg::TN_EL)
                  rsp_in.event_res = tad_pkg::EV_ERASE_LINE;
            end
         end else begin
            // count of 3 cannot occur; it is handled as the last byte
            seq_count_in        = 2'd0;
            rsp_in.event_res    = tad_pkg::EV_REPLY;
            rsp_in.reply_option = b;
            case (seq_second_ff)
               tad_pkg::TN_WILL: rsp_in.reply_verb = ok ? tad_pkg::TN_DO : tad_pkg::TN_DONT;
               tad_pkg::TN_DO:   rsp_in.reply_verb = ok ? tad_pkg::TN_WILL : tad_pkg::TN_WONT;
               tad_pkg::TN_WONT: rsp_in.reply_verb = tad_pkg::TN_DONT;
               default:          rsp_in.reply_verb = tad_pkg::TN_WONT;
            endcase
         end
      end else if (seq_count_ff != 2'd0) begin
         if (seq_count_ff == 2'd1) begin
            seq_second_in = b;
            seq_count_in  = 2'd2;
         end else begin
            seq_count_in = 2'd0;
            if (seq_second_ff inside {tad_pkg::BYTE_LBRK, tad_pkg::BYTE_UCO}) begin
               case (b)
                  tad_pkg::BYTE_UCA: rsp_in.event_res = tad_pkg::EV_UP;
                  tad_pkg::BYTE_UCB: rsp_in.event_res = tad_pkg::EV_DOWN;
                  tad_pkg::BYTE_UCC: rsp_in.event_res = tad_pkg::EV_RIGHT;
                  tad_pkg::BYTE_UCD: rsp_in.event_res = tad_pkg::EV_LEFT;
                  default:           rsp_in.event_res = tad_pkg::EV_NONE;
               endcase
            end
         end
      end else begin
         rsp_in.pass_byte = b;
         if (b inside {tad_pkg::BYTE_BS, tad_pkg::BYTE_DEL})
            rsp_in.event_res = tad_pkg::EV_DELETE;
         else if (b == tad_pkg::BYTE_CTRC)
            rsp_in.event_res = tad_pkg::EV_CTRL_C;
         else if (b inside {[tad_pkg::BYTE_SPACE : tad_pkg::BYTE_TILDE]})
            rsp_in.event_res = tad_pkg::EV_INSERT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         telnet_mode_ff   <= 1'b0;
         seq_count_ff     <= 2'd0;
         seq_is_telnet_ff <= 1'b0;
         seq_second_ff    <= 8'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write && csr_paddr[2] == tad_pkg::REG_TELNET_MODE)
            telnet_mode_ff <= csr_pwdata[0];
         if (accept) begin
            seq_count_ff     <= seq_count_in;
            seq_is_telnet_ff <= seq_is_telnet_in;
            seq_second_ff    <= seq_second_in;
         end
         if (accept)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_event_res    = rsp_ff.event_res;
   assign rsp_pass_byte    = rsp_ff.pass_byte;
   assign rsp_reply_verb   = rsp_ff.reply_verb;
   assign rsp_reply_option = rsp_ff.reply_option;

   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      accept && !lead && seq_count_ff == 2'd0 |=>
         rsp_valid && rsp_pass_byte == $past(req_rx_byte))
      else $error("byte outside a sequence not passed through");

   a_lead_opens: assert property (@(posedge clock) disable iff (reset)
      accept && lead |=> seq_count_ff == 2'd1 && rsp_event_res == tad_pkg::EV_NONE)
      else $error("lead byte did not open a sequence");

   a_verb_only_on_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != tad_pkg::EV_REPLY |-> rsp_reply_verb == 8'd0)
      else $error("reply verb set without a reply event");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      seq_count_ff != 2'd3)
      else $error("sequence count out of range");

endmodule

>>> bench/tb_telnet_ansi_key_decoder.sv
`timescale 1ns / 100ps

class key_event_scoreboard;
   bit                  telnet_on;
   logic [1:0]          seq_len;
   bit                  seq_from_iac;
   logic [7:0]          seq_second_byte;
   tad_pkg::result_type pending_events[$];
   int                  fail_count;

   function new();
      telnet_on = 1'b0;
      seq_len = 2'd0;
      seq_from_iac = 1'b0;
      seq_second_byte = 8'd0;
      fail_count = 0;
   endfunction

   function void set_telnet_mode(bit on);
      telnet_on = on;
   endfunction

   task report(string msg);
      fail_count++;
      $display("[%0t] MISMATCH %s", $time, msg);
   endtask

   function logic [7:0] reply_for(logic [7:0] verb, logic [7:0] opt);
      bit ok;
      ok = (opt == tad_pkg::OPT_ECHO) || (opt == tad_pkg::OPT_SGA);
      case (verb)
         tad_pkg::TN_WILL: reply_for = ok ? tad_pkg::TN_DO : tad_pkg::TN_DONT;
         tad_pkg::TN_DO:   reply_for = ok ? tad_pkg::TN_WILL : tad_pkg::TN_WONT;
         tad_pkg::TN_WONT: reply_for = tad_pkg::TN_DONT;
         default:          reply_for = tad_pkg::TN_WONT;
      endcase
   endfunction

   function tad_pkg::result_type decode_byte(logic [7:0] b);
      tad_pkg::result_type r;
      r = '0;
      if ((telnet_on && b == tad_pkg::TN_IAC) || b == tad_pkg::BYTE_ESC) begin
         // a lead byte always (re)opens a sequence
         seq_from_iac = (b == tad_pkg::TN_IAC);
         seq_len = 2'd1;
      end else if (seq_len != 2'd0 && seq_from_iac) begin
         if (seq_len == 2'd1) begin
            seq_second_byte = b;
            if (b >= tad_pkg::TN_WILL && b <= tad_pkg::TN_DONT) begin
               seq_len = 2'd2;
            end else begin
               seq_len = 2'd0;
               case (b)
                  tad_pkg::TN_BRK, tad_pkg::TN_IP: r.event_res = tad_pkg::EV_TN_BREAK;
                  tad_pkg::TN_EC:  r.event_res = tad_pkg::EV_ERASE_CHAR;
                  tad_pkg::TN_EL:  r.event_res = tad_pkg::EV_ERASE_LINE;
                  default:         r.event_res = tad_pkg::EV_NONE;
               endcase
            end
         end else begin
            r.event_res = tad_pkg::EV_REPLY;
            r.reply_verb = reply_for(seq_second_byte, b);
            r.reply_option = b;
            seq_len = 2'd0;
         end
      end else if (seq_len != 2'd0) begin
         if (seq_len == 2'd1) begin
            seq_second_byte = b;
            seq_len = 2'd2;
         end else begin
            seq_len = 2'd0;
            if (seq_second_byte == tad_pkg::BYTE_LBRK ||
                seq_second_byte == tad_pkg::BYTE_UCO) begin
               case (b)
                  tad_pkg::BYTE_UCA: r.event_res = tad_pkg::EV_UP;
                  tad_pkg::BYTE_UCB: r.event_res = tad_pkg::EV_DOWN;
                  tad_pkg::BYTE_UCC: r.event_res = tad_pkg::EV_RIGHT;
                  tad_pkg::BYTE_UCD: r.event_res = tad_pkg::EV_LEFT;
                  default:           r.event_res = tad_pkg::EV_NONE;
               endcase
            end
         end
      end else begin
         r.pass_byte = b;
         if (b == tad_pkg::BYTE_BS || b == tad_pkg::BYTE_DEL)
            r.event_res = tad_pkg::EV_DELETE;
         else if (b == tad_pkg::BYTE_CTRC)
            r.event_res = tad_pkg::EV_CTRL_C;
         else if (b >= tad_pkg::BYTE_SPACE && b <= tad_pkg::BYTE_TILDE)
            r.event_res = tad_pkg::EV_INSERT;
      end
      return r;
   endfunction

   function void note_byte(logic [7:0] b);
      pending_events.push_back(decode_byte(b));
   endfunction

   task check_result(logic [3:0] ev, logic [7:0] pass, logic [7:0] verb,
                     logic [7:0] opt);
      tad_pkg::result_type want;
      if (pending_events.size() == 0) begin
         report($sformatf("unexpected transaction: event %0d pass %0d verb %0d option %0d",
                          ev, pass, verb, opt));
         return;
      end
      want = pending_events.pop_front();
      if (ev !== want.event_res)
         report($sformatf("event_res got %0d want %0d", ev, want.event_res));
      if (pass !== want.pass_byte)
         report($sformatf("pass_byte got %0d want %0d", pass, want.pass_byte));
      if (verb !== want.reply_verb)
         report($sformatf("reply_verb got %0d want %0d", verb, want.reply_verb));
      if (opt !== want.reply_option)
         report($sformatf("reply_option got %0d want %0d", opt, want.reply_option));
   endtask
endclass

module tb_telnet_ansi_key_decoder;

   localparam logic [2:0] TELNET_MODE_ADDR = 3'(tad_pkg::REG_TELNET_MODE) << 2;
   localparam int HOLD_OFF_CYCLES = 40;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 140;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_res;
   logic [7:0]  rsp_pass_byte;
   logic [7:0]  rsp_reply_verb;
   logic [7:0]  rsp_reply_option;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   key_event_scoreboard sb = new();
   bit no_idle = 1'b0;
   bit hold_off_request = 1'b0;
   int sent_count = 0;

   telnet_ansi_key_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_res    (rsp_event_res),
      .rsp_pass_byte    (rsp_pass_byte),
      .rsp_reply_verb   (rsp_reply_verb),
      .rsp_reply_option (rsp_reply_option),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #6 clock = ~clock;

   function automatic int gap_length();
      if ($urandom_range(0, 7) == 0) return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic int sender_gap();
      if (no_idle || $urandom_range(0, 99) < 60) return 0;
      return gap_length();
   endfunction

   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      sent_count++;
   endtask

   task automatic send_bytes(logic [7:0] bytes[$]);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // stop offering and let every outstanding event come back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_events.size() != 0);
   endtask

   task automatic csr_access(bit wr, logic [31:0] wdata, output logic [31:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= TELNET_MODE_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_telnet_mode(bit on);
      logic [31:0] wdata;
      logic [31:0] rdata;
      wdata = $urandom();
      wdata[0] = on;
      csr_access(1'b1, wdata, rdata);
      sb.set_telnet_mode(on);
      csr_access(1'b0, 32'd0, rdata);
      if (rdata[0] !== on)
         sb.report($sformatf("telnet_mode read back %0d want %0d", rdata[0], on));
   endtask

   task automatic send_burst();
      int roll;
      logic [7:0] pick;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         send_byte(8'($urandom_range(0, 255)));
      end else if (roll < 32) begin
         case ($urandom_range(0, 3))
            0: pick = tad_pkg::BYTE_BS;
            1: pick = tad_pkg::BYTE_DEL;
            2: pick = tad_pkg::BYTE_CTRC;
            default: pick = 8'($urandom_range(tad_pkg::BYTE_SPACE, tad_pkg::BYTE_TILDE));
         endcase
         send_byte(pick);
      end else if (roll < 50) begin
         send_byte(tad_pkg::BYTE_ESC);
         send_byte($urandom_range(0, 1) ? tad_pkg::BYTE_LBRK : tad_pkg::BYTE_UCO);
         if ($urandom_range(0, 4) == 0) send_byte(8'($urandom_range(0, 255)));
         else send_byte(8'($urandom_range(tad_pkg::BYTE_UCA, tad_pkg::BYTE_UCD)));
      end else if (roll < 58) begin
         send_byte(tad_pkg::BYTE_ESC);
         send_byte(8'($urandom_range(0, 255)));
         send_byte(8'($urandom_range(0, 255)));
      end else if (roll < 78) begin
         send_byte(tad_pkg::TN_IAC);
         send_byte(8'($urandom_range(tad_pkg::TN_WILL, tad_pkg::TN_DONT)));
         case ($urandom_range(0, 2))
            0: pick = tad_pkg::OPT_ECHO;
            1: pick = tad_pkg::OPT_SGA;
            default: pick = 8'($urandom_range(0, 255));
         endcase
         send_byte(pick);
      end else if (roll < 90) begin
         send_byte(tad_pkg::TN_IAC);
         case ($urandom_range(0, 4))
            0: pick = tad_pkg::TN_BRK;
            1: pick = tad_pkg::TN_IP;
            2: pick = tad_pkg::TN_EC;
            3: pick = tad_pkg::TN_EL;
            default: pick = 8'($urandom_range(0, 255));
         endcase
         send_byte(pick);
      end else begin
         // broken sequence: a second lead byte cuts the first one short
         send_byte($urandom_range(0, 1) ? tad_pkg::BYTE_ESC : tad_pkg::TN_IAC);
         if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
         send_byte($urandom_range(0, 1) ? tad_pkg::BYTE_ESC : tad_pkg::TN_IAC);
         send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_event_res, rsp_pass_byte, rsp_reply_verb, rsp_reply_option);
         if (hold_off_request) begin
            stall_left = HOLD_OFF_CYCLES;
            hold_off_request = 1'b0;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (no_idle || $urandom_range(0, 99) < 70) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            stall_left = gap_length() - 1;
         end
      end
   end

   initial begin : stimulus
      int target;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_telnet_mode(1'b0);

      // plain keys, arrows, restart mid-sequence, bad final byte, ESC left open
      send_bytes('{8'h00, tad_pkg::TN_IAC, tad_pkg::BYTE_BS, tad_pkg::BYTE_DEL,
                   tad_pkg::BYTE_CTRC, tad_pkg::BYTE_TILDE, 8'h80,
                   tad_pkg::BYTE_ESC, tad_pkg::BYTE_LBRK, tad_pkg::BYTE_UCA,
                   tad_pkg::BYTE_ESC, tad_pkg::BYTE_LBRK, tad_pkg::BYTE_ESC,
                   tad_pkg::BYTE_UCO, tad_pkg::BYTE_UCD,
                   tad_pkg::BYTE_ESC, tad_pkg::BYTE_LBRK, 8'h5A, tad_pkg::BYTE_SPACE,
                   tad_pkg::BYTE_ESC});
      wait_results_drained();
      set_telnet_mode(1'b1);
      // escape sequence opened before the mode change finishes as escape
      send_bytes('{tad_pkg::BYTE_LBRK, tad_pkg::BYTE_UCB,
                   tad_pkg::TN_IAC, tad_pkg::TN_WILL, tad_pkg::OPT_ECHO,
                   tad_pkg::TN_IAC, tad_pkg::TN_DO, 8'hC8,
                   tad_pkg::TN_IAC, tad_pkg::TN_IP, tad_pkg::TN_IAC});
      wait_results_drained();
      set_telnet_mode(1'b0);
      // telnet sequence survives the switch; 255 is now only an option byte
      send_bytes('{tad_pkg::TN_WONT, tad_pkg::TN_IAC});
      wait_results_drained();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_telnet_mode(phase % 3 != 0);
         no_idle = (phase == 5);
         if (phase == 2) hold_off_request = 1'b1;
         target = sent_count + ITEMS_PER_PHASE;
         while (sent_count < target) begin
            send_burst();
            if (phase == 4 && sent_count >= target - ITEMS_PER_PHASE / 2 && !no_idle) begin
               wait_results_drained();
               no_idle = 1'b1;
            end
         end
         no_idle = 1'b0;
         wait_results_drained();
      end

      repeat (8) @(posedge clock);
      if (sb.pending_events.size() != 0)
         sb.report($sformatf("%0d events never arrived", sb.pending_events.size()));
      if (sb.fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
